FILE: design/ott_pkg.sv
package ott_pkg;

  localparam int NUM_MAPS = 4;
  localparam int ENTRIES  = 16;
  localparam int MAP_W    = $clog2(NUM_MAPS);
  localparam int ENT_W    = $clog2(ENTRIES);
  localparam int DEPTH    = NUM_MAPS * ENTRIES;
  localparam int ADDR_W   = MAP_W + ENT_W;
  localparam int AGE_W    = 17;
  localparam int LIM_W    = 16;
  localparam int SQ_W     = 33;
  localparam int DIST_W   = 34;

  typedef enum logic [2:0] {
    MODE_INIT = 3'd0,
    MODE_TICK = 3'd1,
    MODE_FIND = 3'd2,
    MODE_ADD  = 3'd3,
    MODE_READ = 3'd4
  } mode_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic signed [15:0] heading;
    logic [2:0]         kind;
    logic [AGE_W-1:0]   age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/ott_ram.sv
module ott_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/object_track_table_core.sv
// Object track table: four maps of sixteen tracked objects, one operation per input beat and
// one result beat per operation. The entries live in one RAM and are walked one at a time by
// a small sequencer with a single shared squaring unit: init, tick and add visit each entry
// with a read step and an evaluate step, find adds a distance step per entry, and read visits
// only the selected entry; the RAM's single read port sets the pace. No input beat is taken
// while an operation is in progress. After reset all entries read as zero, no clearing pass.
module object_track_table_core
  import ott_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_mode,
  input  logic [1:0]         in_map_sel,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic signed [15:0] in_heading,
  input  logic [2:0]         in_kind,
  input  logic [7:0]         in_entry_sel,
  input  logic [15:0]        in_age_limit,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         out_entry_index,
  output logic               out_hit,
  output logic               out_entry_live,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  output logic signed [15:0] out_heading,
  output logic [2:0]         out_kind,
  output logic [16:0]        out_age
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_EV   = 5'b00100,
    S_DY   = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]         mode_r;
  logic               bad_r;
  logic [MAP_W-1:0]   map_r;
  logic signed [15:0] px_r, py_r, pz_r, ph_r;
  logic [2:0]         kind_r;
  logic [LIM_W-1:0]   lim_in_r;
  logic [ENT_W-1:0]   idx_r;
  logic [LIM_W-1:0]   limit_r [NUM_MAPS];
  logic [DEPTH-1:0]   valid_r;
  logic               rvalid_r;

  entry_t             cur;
  entry_t             best_e_r;
  logic [ENT_W-1:0]   best_idx_r;
  logic               found_r;
  logic [DIST_W-1:0]  best_d_r;
  logic [SQ_W-1:0]    sq_r;
  logic               stale_r;
  logic [AGE_W-1:0]   maxage_r;

  logic [ENTRY_W-1:0] rdata;
  logic               we;
  logic [ADDR_W-1:0]  waddr, raddr;
  entry_t             wdata;

  logic [LIM_W-1:0]   lim_cur;
  logic signed [16:0] diff;
  logic signed [33:0] prod;
  logic [DIST_W-1:0]  dist_sum;
  logic               live, cand, last, fin_go;
  logic [ENT_W-1:0]   sel_clamp;

  assign lim_cur = limit_r[map_r];
  assign cur     = rvalid_r ? entry_t'(rdata) : '0;
  assign last    = (idx_r == ENT_W'(ENTRIES - 1));
  assign live    = ({1'b0, cur.age} < {1'b0, lim_cur, 1'b0} >> 1);
  assign cand    = live && (cur.kind == kind_r);
  assign fin_go  = !out_valid || !out_stall;
  assign sel_clamp = ({1'b0, in_entry_sel} < 9'(ENTRIES)) ? in_entry_sel[ENT_W-1:0] : '0;

  // shared squaring unit: dx in S_EV, dy in S_DY
  always_comb begin
    if (state_r == S_DY) begin
      diff = {cur.y[15], cur.y} - {py_r[15], py_r};
    end else begin
      diff = {cur.x[15], cur.x} - {px_r[15], px_r};
    end
    prod = diff * diff;
    dist_sum = {1'b0, sq_r} + {1'b0, prod[SQ_W-1:0]};
  end

  assign raddr = {map_r, idx_r};

  always_comb begin
    we    = 1'b0;
    waddr = {map_r, idx_r};
    wdata = cur;
    if (state_r == S_EV) begin
      unique case (mode_t'(mode_r))
        MODE_INIT: begin
          we        = 1'b1;
          wdata.age = {1'b0, lim_in_r} + 17'd1;
        end
        MODE_TICK: begin
          we        = (cur.age <= {1'b0, lim_cur});
          wdata.age = cur.age + 17'd1;
        end
        default: we = 1'b0;
      endcase
    end else if (state_r == S_FIN && fin_go && !bad_r) begin
      unique case (mode_t'(mode_r))
        MODE_FIND: begin
          we        = found_r;
          waddr     = {map_r, best_idx_r};
          wdata     = best_e_r;
          wdata.age = '0;
        end
        MODE_ADD: begin
          we      = 1'b1;
          waddr   = {map_r, best_idx_r};
          wdata.x = px_r;
          wdata.y = py_r;
          wdata.z = pz_r;
          wdata.heading = ph_r;
          wdata.kind = kind_r;
          wdata.age  = '0;
        end
        default: we = 1'b0;
      endcase
    end
  end

  ott_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_RD;
          if (!(mode_t'(in_mode) inside {MODE_INIT, MODE_TICK, MODE_FIND, MODE_ADD, MODE_READ})
              || ({1'b0, in_map_sel} >= 3'(NUM_MAPS))) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        if (mode_r == MODE_FIND) begin
          state_nxt = S_DY;
        end else if (mode_r == MODE_READ || last) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DY: state_nxt = last ? S_FIN : S_RD;
      S_FIN: begin
        if (fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      valid_r   <= '0;
      out_valid <= 1'b0;
      rvalid_r  <= 1'b0;
      for (int i = 0; i < NUM_MAPS; i++) begin
        limit_r[i] <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      rvalid_r <= valid_r[raddr];
      if (we) begin
        valid_r[waddr] <= 1'b1;
      end
      if (state_r == S_IDLE && in_valid && in_mode == MODE_INIT &&
          {1'b0, in_map_sel} < 3'(NUM_MAPS)) begin
        limit_r[in_map_sel[MAP_W-1:0]] <= in_age_limit;
      end
      if (state_r == S_FIN && fin_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        mode_r   <= in_mode;
        bad_r    <= !(mode_t'(in_mode) inside {MODE_INIT, MODE_TICK, MODE_FIND, MODE_ADD,
                      MODE_READ}) || ({1'b0, in_map_sel} >= 3'(NUM_MAPS));
        map_r    <= in_map_sel[MAP_W-1:0];
        px_r     <= in_pos_x;
        py_r     <= in_pos_y;
        pz_r     <= in_pos_z;
        ph_r     <= in_heading;
        kind_r   <= in_kind;
        lim_in_r <= in_age_limit;
        idx_r    <= (in_mode == MODE_READ) ? sel_clamp : '0;
        found_r  <= 1'b0;
        stale_r  <= 1'b0;
        maxage_r <= '0;
        best_idx_r <= '0;
        best_d_r <= '0;
      end
      S_EV: begin
        sq_r <= prod[SQ_W-1:0];
        if (mode_r == MODE_READ) begin
          best_e_r <= cur;
        end
        if (mode_r == MODE_ADD && !stale_r) begin
          if (!live) begin
            stale_r    <= 1'b1;
            best_idx_r <= idx_r;
          end else if (cur.age > maxage_r) begin
            maxage_r   <= cur.age;
            best_idx_r <= idx_r;
          end
        end
        if (mode_r != MODE_FIND && mode_r != MODE_READ && !last) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      S_DY: begin
        if (cand && (!found_r || dist_sum < best_d_r)) begin
          found_r    <= 1'b1;
          best_d_r   <= dist_sum;
          best_idx_r <= idx_r;
          best_e_r   <= cur;
        end
        if (!last) begin
          idx_r <= idx_r + 1'b1;
        end
      end
      S_FIN: begin
        if (fin_go) begin
          out_entry_index <= '0;
          out_hit         <= 1'b0;
          out_entry_live  <= 1'b0;
          out_x           <= '0;
          out_y           <= '0;
          out_z           <= '0;
          out_heading     <= '0;
          out_kind        <= '0;
          out_age         <= '0;
          if (!bad_r && (mode_r == MODE_READ || mode_r == MODE_ADD ||
              (mode_r == MODE_FIND && found_r))) begin
            out_entry_index <= 4'((mode_r == MODE_READ) ? idx_r : best_idx_r);
            out_hit         <= (mode_r == MODE_FIND);
            out_x           <= wdata.x;
            out_y           <= wdata.y;
            out_z           <= wdata.z;
            out_heading     <= wdata.heading;
            out_kind        <= wdata.kind;
            out_age         <= wdata.age;
            out_entry_live  <= (wdata.age < {1'b0, lim_cur});
          end
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == S_EV || state_r == S_FIN))
    else $error("ram write outside scan or finish");
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && fin_go) |=> out_valid)
    else $error("finished operation gave no result beat");
  a_dy_after_ev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DY) |-> ($past(state_r) == S_EV && mode_r == MODE_FIND))
    else $error("distance step out of order");
`endif

endmodule
